// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle that ante holds.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/uoff_pkg.sv =====
// Types and constants shared by the offset mapper modules.
package uoff_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 2;
	localparam int OFFSET_BITS       = 17;
	localparam int LIMIT_BITS        = 16;
	localparam int POS_OUT_BITS      = 16;

	// Sequence length announced by a lead byte (code + 1 bytes)
	typedef enum logic [1:0] {
		LEN_1,
		LEN_2,
		LEN_3,
		LEN_4
	} seq_len_t;

	// Classified request handed from the front end to the back end
	typedef struct packed {
		logic                  func;
		logic                  has_byte;
		logic                  first;
		logic                  last;
		seq_len_t              lead_len;
		logic                  lo3_nz;   // low three bits of a lead are nonzero
		logic                  mid2_nz;  // bits 5:4 of a continuation are nonzero
		logic [LIMIT_BITS-1:0] limit;    // clamped offset or target
	} item_t;

	typedef struct packed {
		logic [POS_OUT_BITS-1:0] position;
		logic                    overflow;
	} result_t;

endpackage

// ===== hw/rtl/uoff_fifo.sv =====
// Small first-in first-out queue with full and empty flags.
module uoff_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = uoff_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/uoff_front.sv =====
// Front end: classify the lead byte and clamp the line offset.
module uoff_front #(
	parameter int POSITION_BITS = uoff_pkg::POSITION_BITS_DEF
) (
	input  logic                                   func,
	input  logic [7:0]                             text_byte,
	input  logic                                   has_byte,
	input  logic                                   first,
	input  logic                                   last,
	input  logic signed [uoff_pkg::OFFSET_BITS-1:0] offset_in,
	output uoff_pkg::item_t                        item
);

	localparam int LB = uoff_pkg::LIMIT_BITS;
	localparam logic [LB-1:0] LIM_MAX = (POSITION_BITS >= LB) ? {LB{1'b1}} :
		LB'((64'd1 << POSITION_BITS) - 64'd1);

	localparam logic [7:0] MASK_LEN2 = 8'he0;
	localparam logic [7:0] LEAD_LEN2 = 8'hc0;
	localparam logic [7:0] MASK_LEN3 = 8'hf0;
	localparam logic [7:0] LEAD_LEN3 = 8'he0;
	localparam logic [7:0] MASK_LEN4 = 8'hf8;
	localparam logic [7:0] LEAD_LEN4 = 8'hf0;
	localparam logic [7:0] LEAD_LOW  = 8'h07;
	localparam logic [7:0] CONT_HIGH = 8'h30;

	logic [LB-1:0] magnitude;

	always_comb begin
		magnitude     = offset_in[LB-1:0];
		item.func     = func;
		item.has_byte = has_byte;
		item.first    = first;
		item.last     = last;

		if ((text_byte & MASK_LEN2) == LEAD_LEN2) begin
			item.lead_len = uoff_pkg::LEN_2;
		end else if ((text_byte & MASK_LEN3) == LEAD_LEN3) begin
			item.lead_len = uoff_pkg::LEN_3;
		end else if ((text_byte & MASK_LEN4) == LEAD_LEN4) begin
			item.lead_len = uoff_pkg::LEN_4;
		end else begin
			item.lead_len = uoff_pkg::LEN_1;
		end

		// Bits that push a four-byte code point above the basic plane
		item.lo3_nz  = |(text_byte & LEAD_LOW);
		item.mid2_nz = |(text_byte & CONT_HIGH);

		if (offset_in[uoff_pkg::OFFSET_BITS-1]) begin
			item.limit = '0;
		end else if (magnitude > LIM_MAX) begin
			item.limit = LIM_MAX;
		end else begin
			item.limit = magnitude;
		end
	end

endmodule

// ===== hw/rtl/uoff_back.sv =====
// Back end: per-line counters, pending sequence and end-of-line flush.
module uoff_back #(
	parameter int POSITION_BITS = uoff_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  uoff_pkg::item_t   item,
	output logic              in_pop,
	input  logic              out_full,
	output logic              out_push,
	output uoff_pkg::result_t result
);

	localparam int PB = POSITION_BITS;
	localparam int WB = POSITION_BITS + 2;
	localparam int OB = uoff_pkg::POS_OUT_BITS;
	localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

	// Line state
	logic [PB-1:0]      byte_pos_q;
	logic [PB-1:0]      unit_count_q;
	logic [1:0]         pend_count_q;
	logic               line_mode_q;
	logic [PB-1:0]      line_limit_q;
	logic               answer_found_q;
	logic [PB-1:0]      answer_value_q;
	logic               saturated_q;
	uoff_pkg::seq_len_t pend0_len_q;
	logic               pend0_hi_q;
	logic               pend1_is2_q;
	logic               pend1_hi_q;

	// Next-state working values
	logic               go;
	logic [PB-1:0]      bp;
	logic [PB-1:0]      uc;
	logic [1:0]         pc;
	logic               mode;
	logic [PB-1:0]      lim;
	logic               fnd;
	logic [PB-1:0]      ans;
	logic               sat;
	uoff_pkg::seq_len_t p0len;
	logic               p0hi;
	logic               p1is2;
	logic               p1hi;
	logic [PB-1:0]      p;
	logic               relevant;
	logic               fits;
	logic               fin_en;
	logic [1:0]         fin_units;
	logic [WB-1:0]      fin_end;
	logic [WB-1:0]      sum;
	logic [PB-1:0]      end_sat;
	logic [PB-1:0]      uc_base;
	logic [PB-1:0]      start;
	logic [PB-1:0]      end_j;
	logic               pair;
	logic [1:0]         cnt;
	logic [PB-1:0]      pos;

	assign go       = in_valid && (!item.last || !out_full);
	assign in_pop   = go;
	assign out_push = go && item.last;

	always_comb begin
		// Restart the line on first, otherwise carry on
		if (item.first) begin
			bp   = '0;
			uc   = '0;
			pc   = '0;
			mode = item.func;
			lim  = PB'(item.limit);
			fnd  = item.func && (item.limit == '0);
			ans  = '0;
			sat  = 1'b0;
		end else begin
			bp   = byte_pos_q;
			uc   = unit_count_q;
			pc   = pend_count_q;
			mode = line_mode_q;
			lim  = line_limit_q;
			fnd  = answer_found_q;
			ans  = answer_value_q;
			sat  = saturated_q;
		end
		p0len     = pend0_len_q;
		p0hi      = pend0_hi_q;
		p1is2     = pend1_is2_q;
		p1hi      = pend1_hi_q;
		p         = bp;
		relevant  = 1'b0;
		fits      = 1'b0;
		fin_en    = 1'b0;
		fin_units = 2'd1;
		fin_end   = '0;
		sum       = '0;
		end_sat   = '0;
		uc_base   = '0;
		start     = '0;
		end_j     = '0;
		pair      = 1'b0;
		cnt       = '0;

		// Consume the byte
		if (item.has_byte) begin
			if (bp != POS_MAX) begin
				bp = bp + 1'b1;
			end else if (mode ? !fnd : (lim == POS_MAX)) begin
				sat = 1'b1;
			end
			relevant = mode ? !fnd : ((pc != 2'd0) || (p < lim));
			if (relevant) begin
				if (pc != 2'd0) begin
					if (pc >= 2'(p0len)) begin
						// Sequence complete: only a four-byte one above the plane counts two
						fin_en    = 1'b1;
						fin_units = ((p0len == uoff_pkg::LEN_4) && (p0hi || p1hi)) ? 2'd2 : 2'd1;
						fin_end   = WB'(p) + WB'(1);
						pc        = 2'd0;
					end else begin
						if (pc == 2'd1) begin
							p1is2 = (item.lead_len == uoff_pkg::LEN_2);
							p1hi  = item.mid2_nz;
						end
						pc = pc + 2'd1;
					end
				end else begin
					fits = (item.lead_len != uoff_pkg::LEN_1) &&
						(mode || (WB'(p) + WB'(item.lead_len) + WB'(1) <= WB'(lim)));
					if (fits) begin
						p0len = item.lead_len;
						p0hi  = item.lo3_nz;
						pc    = 2'd1;
					end else begin
						fin_en  = 1'b1;
						fin_end = WB'(p) + WB'(1);
					end
				end
			end
		end

		// Finish the character that this byte closed
		if (fin_en && !(mode && fnd)) begin
			sum = WB'(uc) + WB'(fin_units);
			if (sum > WB'(POS_MAX)) begin
				uc  = POS_MAX;
				sat = 1'b1;
			end else begin
				uc = PB'(sum);
			end
			if (fin_end > WB'(POS_MAX)) begin
				end_sat = POS_MAX;
				sat     = 1'b1;
			end else begin
				end_sat = PB'(fin_end);
			end
			if (mode && (uc >= lim)) begin
				fnd = 1'b1;
				ans = end_sat;
			end
		end

		// Flush a truncated sequence at line end, one unit per character
		if (item.last && (pc != 2'd0)) begin
			uc_base = uc;
			start   = bp - PB'(pc);
			pair    = (pc == 2'd3) && p1is2;
			cnt     = pair ? 2'd2 : pc;
			for (int j = 0; j < 3; j++) begin
				if ((2'(j) < cnt) && !(mode && fnd)) begin
					end_j = (pair && (j == 1)) ? bp : start + PB'(j + 1);
					sum   = WB'(uc_base) + WB'(j + 1);
					if (sum > WB'(POS_MAX)) begin
						uc  = POS_MAX;
						sat = 1'b1;
					end else begin
						uc = PB'(sum);
					end
					if (mode && (uc >= lim)) begin
						fnd = 1'b1;
						ans = end_j;
					end
				end
			end
			pc = 2'd0;
		end

		pos             = mode ? (fnd ? ans : bp) : uc;
		result.position = OB'(pos);
		result.overflow = sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q     <= '0;
			unit_count_q   <= '0;
			pend_count_q   <= '0;
			line_mode_q    <= 1'b0;
			line_limit_q   <= '0;
			answer_found_q <= 1'b0;
			answer_value_q <= '0;
			saturated_q    <= 1'b0;
		end else if (go) begin
			byte_pos_q     <= bp;
			unit_count_q   <= uc;
			pend_count_q   <= pc;
			line_mode_q    <= mode;
			line_limit_q   <= lim;
			answer_found_q <= fnd;
			answer_value_q <= ans;
			saturated_q    <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pend0_len_q <= p0len;
			pend0_hi_q  <= p0hi;
			pend1_is2_q <= p1is2;
			pend1_hi_q  <= p1hi;
		end
	end

endmodule

// ===== hw/rtl/utf8_utf16_offset_mapper.sv =====
// Top level of the UTF-8 line to UTF-16 offset mapper.
// Feed the bytes of one UTF-8 line, one request per byte, with first on the
// opening request (it carries func and offset_in) and last on the closing one;
// a line with no text is one request with has_byte low. func 0 returns the
// number of UTF-16 code units in the first offset_in bytes, func 1 returns
// the byte position at which the unit count first reaches offset_in (zero for
// a target of zero, the line length if never reached). Negative offsets clamp
// to zero; counts and positions saturate at the largest position value and
// raise overflow. Exactly one result is produced per line, on the closing
// request, which the back end retires into the result queue; it is held back
// only while the back end waits on a full result queue. The block takes one
// byte every cycle while full is low: the front end classifies each byte
// combinationally into a QUEUE_DEPTH-entry request queue, the back end retires
// one request per cycle unless it waits on the result queue, updating all line
// state as it retires (including the flush of up to three pending bytes at
// line end), and a QUEUE_DEPTH-entry result queue decouples it from the
// consumer. full rises only when the result queue is full and the back end
// holds a closing request; with results popped on time, no bubble is inserted.
module utf8_utf16_offset_mapper #(
	parameter int POSITION_BITS = uoff_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH   = uoff_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic                                    func,
	input  logic [7:0]                              text_byte,
	input  logic                                    has_byte,
	input  logic                                    first,
	input  logic                                    last,
	input  logic signed [uoff_pkg::OFFSET_BITS-1:0] offset_in,
	output logic                                    empty,
	input  logic                                    pop,
	output logic [uoff_pkg::POS_OUT_BITS-1:0]       position,
	output logic                                    overflow
);

	uoff_pkg::item_t   item_in;
	uoff_pkg::item_t   item_head;
	logic              mid_empty;
	logic              mid_pop;
	logic              res_full;
	logic              res_push;
	uoff_pkg::result_t res_in;
	uoff_pkg::result_t res_head;

	// Classify the byte and clamp the offset
	uoff_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.func      (func),
		.text_byte (text_byte),
		.has_byte  (has_byte),
		.first     (first),
		.last      (last),
		.offset_in (offset_in),
		.item      (item_in)
	);

	// Hold classified requests until the back end takes them
	uoff_fifo #(
		.T     (uoff_pkg::item_t),
		.DEPTH (QUEUE_DEPTH)
	) u_req_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (item_in),
		.full  (full),
		.pop   (mid_pop),
		.rdata (item_head),
		.empty (mid_empty)
	);

	// Advance the line state and issue the result on the closing request
	uoff_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(!mid_empty),
		.item    (item_head),
		.in_pop  (mid_pop),
		.out_full(res_full),
		.out_push(res_push),
		.result  (res_in)
	);

	// Hold results until the consumer pops them
	uoff_fifo #(
		.T     (uoff_pkg::result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_head),
		.empty (empty)
	);

	assign position = res_head.position;
	assign overflow = res_head.overflow;

endmodule

// ===== hw/rtl/uoff_checker.sv =====
// Port-level checker for the offset mapper, bound to the top level.
`include "assert_macros.svh"
module uoff_checker #(
	parameter int QUEUE_DEPTH = uoff_pkg::QUEUE_DEPTH_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              push,
	input logic                              full,
	input logic                              last,
	input logic                              empty,
	input logic                              pop,
	input logic [uoff_pkg::POS_OUT_BITS-1:0] position,
	input logic                              overflow
);

	localparam int OW = $clog2(2 * QUEUE_DEPTH + 2);

	// Lines closed at the input whose result has not been popped yet
	logic [OW-1:0] open_q;
	logic          line_in;
	logic          line_out;

	assign line_in  = push && !full && last;
	assign line_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			case ({line_in, line_out})
				2'b10: open_q <= open_q + 1'b1;
				2'b01: open_q <= open_q - 1'b1;
				default: open_q <= open_q;
			endcase
		end
	end

	`ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(position) && $stable(overflow), "result changed while waiting")
	`ASSERT_NOW(a_result_has_line, !empty, open_q != '0, "result without a closed line")
	`ASSERT_NOW(a_full_needs_push, $rose(full), $past(push), "queue filled without a request")

endmodule

bind utf8_utf16_offset_mapper uoff_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_uoff_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.last    (last),
	.empty   (empty),
	.pop     (pop),
	.position(position),
	.overflow(overflow)
);
